// ===== hdl/ofx_pkg.sv =====
package ofx_pkg;

    // default fraction bits of the stored frame (Q3.14)
    localparam int FRAME_FRAC_BITS_DEF = 14;

    // width of the Q3.12 vector fields
    localparam int VEC_W = 16;

    typedef enum logic [1:0] {
        KIND_BUILD_N  = 2'd0,
        KIND_BUILD_NT = 2'd1,
        KIND_TO_LOCAL = 2'd2,
        KIND_TO_WORLD = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_ZERO = 2'd1,
        STAT_SAT  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEN_MUL,
        ST_LEN_ACC,
        ST_SQRT,
        ST_NRM_SET,
        ST_DIV,
        ST_BAS_MUL,
        ST_BAS_SET,
        ST_CRS_MUL,
        ST_CRS_ACC,
        ST_XF_MUL,
        ST_XF_ACC,
        ST_COMMIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [VEC_W-1:0] vec_x;
        logic signed [VEC_W-1:0] vec_y;
        logic signed [VEC_W-1:0] vec_z;
        logic signed [VEC_W-1:0] tan_x;
        logic signed [VEC_W-1:0] tan_y;
        logic signed [VEC_W-1:0] tan_z;
    } in_item_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] out_x;
        logic signed [VEC_W-1:0] out_y;
        logic signed [VEC_W-1:0] out_z;
        logic [1:0]              status;
    } out_item_t;

endpackage

// ===== hdl/orthonormal_frame_transform.sv =====
// Orthonormal frame unit: keeps a frame (u, v, w) in signed fixed point with
// FRAME_FRAC_BITS fraction bits and takes one transaction at a time through a
// small sequencer around one shared multiplier, one bit-per-cycle square root
// and one bit-per-cycle divider. Transforms (world to local, local to world)
// take nine multiply/accumulate pairs. Normalising one vector sums three
// squares, takes one square root and makes three divisions; a build from a
// normal adds three more divisions for the basis, and a build from normal
// and tangent normalises twice and adds six products for the cross product.
// A zero-length build returns status 1 at once and keeps the frame. The
// input is taken only while the sequencer is idle; a finished result sits in
// an output register, so the next transaction may be accepted before the
// previous result is taken.
module orthonormal_frame_transform #(
    parameter int FRAME_FRAC_BITS = ofx_pkg::FRAME_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ofx_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output ofx_pkg::out_item_t out_item
);
    import ofx_pkg::*;

    localparam int F     = FRAME_FRAC_BITS;
    localparam int FW    = F + 4;
    localparam int NW    = F + 2;
    localparam int QW    = F + 2;
    localparam int MW    = (FW > 17) ? FW : 17;
    localparam int PW    = 2 * MW;
    localparam int AW    = PW + 2;
    localparam int DVW   = F + 32;
    localparam int SW    = 64;
    localparam int CW    = $clog2(((QW > 32) ? QW : 32) + 1);
    localparam int RSH   = (F > 12) ? F - 12 : 0;
    localparam int LSH   = (F < 12) ? 12 - F : 0;
    localparam int RND_Q = (F > 12) ? (1 << (F - 13)) : 0;
    localparam int TW    = NW + 5;

    localparam logic signed [FW-1:0] ONE_F  = FW'(1 << F);
    localparam logic [NW-1:0]        ONE_N  = NW'(1 << F);
    localparam logic signed [AW-1:0] SAT_HI = AW'(32767);
    localparam logic signed [AW-1:0] SAT_LO = AW'(-32768);

    // rounded shift right by F, half away from zero
    function automatic logic signed [AW-1:0] rnd_frac(input logic signed [AW-1:0] a);
        logic [AW-1:0] m;
        logic [AW-1:0] q;
        m = a[AW-1] ? AW'(-a) : AW'(a);
        q = (m + (AW'(1) << (F - 1))) >> F;
        return a[AW-1] ? -$signed(q) : $signed(q);
    endfunction

    // frame value to Q3.12, half away from zero
    function automatic logic signed [VEC_W-1:0] to_q12(input logic signed [NW-1:0] a);
        logic [TW-1:0] m;
        logic [TW-1:0] q;
        m = a[NW-1] ? TW'(NW'(-a)) : TW'(NW'(a));
        q = ((m + TW'(RND_Q)) >> RSH) << LSH;
        return a[NW-1] ? VEC_W'(-$signed(q)) : VEC_W'($signed(q));
    endfunction

    function automatic logic signed [MW-1:0] pick3(
        input logic signed [MW-1:0] a0,
        input logic signed [MW-1:0] a1,
        input logic signed [MW-1:0] a2,
        input logic [1:0]           s
    );
        logic signed [MW-1:0] r;
        unique case (s)
            2'd0:    r = a0;
            2'd1:    r = a1;
            default: r = a2;
        endcase
        return r;
    endfunction

    function automatic logic signed [VEC_W-1:0] pick3_vec(
        input logic signed [VEC_W-1:0] a0,
        input logic signed [VEC_W-1:0] a1,
        input logic signed [VEC_W-1:0] a2,
        input logic [1:0]              s
    );
        logic signed [VEC_W-1:0] r;
        unique case (s)
            2'd0:    r = a0;
            2'd1:    r = a1;
            default: r = a2;
        endcase
        return r;
    endfunction

    state_t state_reg, state_next;

    kind_t                   kind_reg;
    logic signed [VEC_W-1:0] vec_reg [3];
    logic signed [VEC_W-1:0] tan_reg [3];
    logic                    pass_reg;
    logic                    bas_reg;
    logic                    zero_reg;
    logic                    sat_reg;
    logic [2:0]              idx_reg;
    logic [1:0]              jdx_reg;
    logic [CW-1:0]           cnt_reg;

    logic signed [PW-1:0]    prod_reg;
    logic signed [AW-1:0]    acc_reg;

    logic [SW-1:0]           sq_x_reg;
    logic [SW-1:0]           sq_res_reg;
    logic [SW-1:0]           sq_bit_reg;

    logic [31:0]             dv_rem_reg;
    logic [QW-1:0]           dv_num_reg;
    logic [QW-1:0]           dv_q_reg;
    logic [31:0]             dv_div_reg;
    logic                    dv_neg_reg;

    logic signed [NW-1:0]    nrm_reg [2][3];
    logic signed [NW-1:0]    bq_reg [3];
    logic signed [FW-1:0]    crs_reg [3];
    logic signed [VEC_W-1:0] res_reg [3];

    logic signed [FW-1:0]    fu_reg [3];
    logic signed [FW-1:0]    fv_reg [3];
    logic signed [FW-1:0]    fw_reg [3];

    out_item_t               out_reg;
    logic                    out_valid_reg, out_valid_next;

    logic                    in_take;
    logic                    in_zero;
    logic                    out_load;
    logic                    mul_en;
    logic signed [MW-1:0]    mul_a;
    logic signed [MW-1:0]    mul_b;
    logic signed [AW-1:0]    acc_add;
    logic signed [AW-1:0]    acc_sub;
    logic [SW-1:0]           sq_sum;
    logic                    sq_ge;
    logic [32:0]             dv_t;
    logic                    dv_ge;
    logic [QW-1:0]           q_fin;
    logic [QW-1:0]           q_clamp;
    logic signed [VEC_W-1:0] cur;
    logic [VEC_W-1:0]        cur_mag;
    logic [DVW-1:0]          nrm_num;
    logic [PW-1:0]           prod_mag;
    logic [NW-1:0]           w2_mag;
    logic [NW-1:0]           d_val;
    logic [DVW-1:0]          bas_num;
    logic signed [AW-1:0]    xf_rnd;
    logic                    w_pos;
    logic [1:0]              xf_ax;
    logic [1:0]              xf_cm;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_take   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // zero-length build detection on the incoming transaction
    assign in_zero = (in_item.vec_x == '0) && (in_item.vec_y == '0) && (in_item.vec_z == '0)
                  || ((kind_t'(in_item.kind) == KIND_BUILD_NT)
                      && (in_item.tan_x == '0) && (in_item.tan_y == '0)
                      && (in_item.tan_z == '0));

    // shared multiplier operand selection
    assign xf_ax = (kind_reg == KIND_TO_LOCAL) ? idx_reg[1:0] : jdx_reg;
    assign xf_cm = (kind_reg == KIND_TO_LOCAL) ? jdx_reg : idx_reg[1:0];

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
        unique case (state_reg)
            ST_LEN_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = MW'(cur);
                mul_b  = MW'(cur);
            end
            ST_BAS_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = (idx_reg == 3'd2) ? MW'(nrm_reg[0][1]) : MW'(nrm_reg[0][0]);
                mul_b  = (idx_reg == 3'd0) ? MW'(nrm_reg[0][0]) : MW'(nrm_reg[0][1]);
            end
            ST_CRS_MUL:
            begin
                mul_en = 1'b1;
                unique case (idx_reg)
                    3'd0:
                    begin
                        mul_a = MW'(nrm_reg[0][1]);
                        mul_b = MW'(nrm_reg[1][2]);
                    end
                    3'd1:
                    begin
                        mul_a = MW'(nrm_reg[0][2]);
                        mul_b = MW'(nrm_reg[1][1]);
                    end
                    3'd2:
                    begin
                        mul_a = MW'(nrm_reg[0][2]);
                        mul_b = MW'(nrm_reg[1][0]);
                    end
                    3'd3:
                    begin
                        mul_a = MW'(nrm_reg[0][0]);
                        mul_b = MW'(nrm_reg[1][2]);
                    end
                    3'd4:
                    begin
                        mul_a = MW'(nrm_reg[0][0]);
                        mul_b = MW'(nrm_reg[1][1]);
                    end
                    default:
                    begin
                        mul_a = MW'(nrm_reg[0][1]);
                        mul_b = MW'(nrm_reg[1][0]);
                    end
                endcase
            end
            ST_XF_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = pick3(MW'(vec_reg[0]), MW'(vec_reg[1]), MW'(vec_reg[2]), jdx_reg);
                mul_b  = pick3(
                    pick3(MW'(fu_reg[0]), MW'(fu_reg[1]), MW'(fu_reg[2]), xf_cm),
                    pick3(MW'(fv_reg[0]), MW'(fv_reg[1]), MW'(fv_reg[2]), xf_cm),
                    pick3(MW'(fw_reg[0]), MW'(fw_reg[1]), MW'(fw_reg[2]), xf_cm),
                    xf_ax);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // accumulator, square root and divider steps
    assign acc_add = acc_reg + AW'(prod_reg);
    assign acc_sub = acc_reg - AW'(prod_reg);

    assign sq_sum = sq_res_reg + sq_bit_reg;
    assign sq_ge  = (sq_x_reg >= sq_sum);

    assign dv_t    = {dv_rem_reg, dv_num_reg[QW-1]};
    assign dv_ge   = (dv_t >= {1'b0, dv_div_reg});
    assign q_fin   = {dv_q_reg[QW-2:0], dv_ge};
    assign q_clamp = (q_fin > ONE_N) ? ONE_N : q_fin;

    // normalisation numerator: |a| << (F+16) plus half the root
    assign cur     = pass_reg ? pick3_vec(tan_reg[0], tan_reg[1], tan_reg[2], idx_reg[1:0])
                              : pick3_vec(vec_reg[0], vec_reg[1], vec_reg[2], idx_reg[1:0]);
    assign cur_mag = cur[VEC_W-1] ? VEC_W'(-cur) : VEC_W'(cur);
    assign nrm_num = (DVW'(cur_mag) << (F + 16)) + DVW'(sq_res_reg[31:1]);

    // basis divisor 2^F + |w.z| and rounded numerator
    assign w_pos    = !nrm_reg[0][2][NW-1];
    assign w2_mag   = w_pos ? NW'(nrm_reg[0][2]) : NW'(-nrm_reg[0][2]);
    assign d_val    = ONE_N + w2_mag;
    assign prod_mag = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
    assign bas_num  = DVW'(prod_mag) + DVW'(d_val >> 1);

    assign xf_rnd = rnd_frac(acc_add);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind_t'(in_item.kind) == KIND_TO_LOCAL
                        || kind_t'(in_item.kind) == KIND_TO_WORLD)
                        state_next = ST_XF_MUL;
                    else if (in_zero)
                        state_next = ST_DONE;
                    else
                        state_next = ST_LEN_MUL;
                end
            end
            ST_LEN_MUL: state_next = ST_LEN_ACC;
            ST_LEN_ACC: state_next = (idx_reg == 3'd2) ? ST_SQRT : ST_LEN_MUL;
            ST_SQRT:
            begin
                if (cnt_reg == CW'(31))
                    state_next = ST_NRM_SET;
            end
            ST_NRM_SET: state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == CW'(QW - 1))
                begin
                    if (!bas_reg)
                    begin
                        if (idx_reg != 3'd2)
                            state_next = ST_NRM_SET;
                        else if (kind_reg == KIND_BUILD_NT && !pass_reg)
                            state_next = ST_LEN_MUL;
                        else if (kind_reg == KIND_BUILD_N)
                            state_next = ST_BAS_MUL;
                        else
                            state_next = ST_CRS_MUL;
                    end
                    else
                    begin
                        state_next = (idx_reg == 3'd2) ? ST_COMMIT : ST_BAS_MUL;
                    end
                end
            end
            ST_BAS_MUL: state_next = ST_BAS_SET;
            ST_BAS_SET: state_next = ST_DIV;
            ST_CRS_MUL: state_next = ST_CRS_ACC;
            ST_CRS_ACC: state_next = (idx_reg == 3'd5) ? ST_COMMIT : ST_CRS_MUL;
            ST_XF_MUL:  state_next = ST_XF_ACC;
            ST_XF_ACC:
            begin
                if (idx_reg == 3'd2 && jdx_reg == 2'd2)
                    state_next = ST_DONE;
                else
                    state_next = ST_XF_MUL;
            end
            ST_COMMIT:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    // control state and frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                fu_reg[i] <= (i == 0) ? ONE_F : '0;
                fv_reg[i] <= (i == 1) ? ONE_F : '0;
                fw_reg[i] <= (i == 2) ? ONE_F : '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_COMMIT)
            begin
                for (int i = 0; i < 3; i++)
                    fw_reg[i] <= FW'(nrm_reg[0][i]);
                if (kind_reg == KIND_BUILD_N)
                begin
                    fu_reg[0] <= ONE_F - FW'(bq_reg[0]);
                    fu_reg[1] <= -FW'(bq_reg[1]);
                    fu_reg[2] <= w_pos ? -FW'(nrm_reg[0][0]) : FW'(nrm_reg[0][0]);
                    fv_reg[0] <= w_pos ? -FW'(bq_reg[1]) : FW'(bq_reg[1]);
                    fv_reg[1] <= w_pos ? ONE_F - FW'(bq_reg[2]) : FW'(bq_reg[2]) - ONE_F;
                    fv_reg[2] <= -FW'(nrm_reg[0][1]);
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        fu_reg[i] <= FW'(nrm_reg[1][i]);
                        fv_reg[i] <= crs_reg[i];
                    end
                end
            end
        end
    end

    // shared multiplier with registered product
    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= mul_a * mul_b;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    kind_reg   <= kind_t'(in_item.kind);
                    vec_reg[0] <= in_item.vec_x;
                    vec_reg[1] <= in_item.vec_y;
                    vec_reg[2] <= in_item.vec_z;
                    tan_reg[0] <= in_item.tan_x;
                    tan_reg[1] <= in_item.tan_y;
                    tan_reg[2] <= in_item.tan_z;
                    zero_reg   <= in_zero && (kind_t'(in_item.kind) == KIND_BUILD_N
                                  || kind_t'(in_item.kind) == KIND_BUILD_NT);
                    sat_reg    <= 1'b0;
                    pass_reg   <= 1'b0;
                    idx_reg    <= '0;
                    jdx_reg    <= '0;
                    acc_reg    <= '0;
                    for (int i = 0; i < 3; i++)
                        res_reg[i] <= '0;
                end
            end
            ST_LEN_ACC:
            begin
                if (idx_reg == 3'd2)
                begin
                    idx_reg    <= '0;
                    acc_reg    <= '0;
                    sq_x_reg   <= {acc_add[31:0], 32'd0};
                    sq_res_reg <= '0;
                    sq_bit_reg <= SW'(1) << (SW - 2);
                    cnt_reg    <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 3'd1;
                    acc_reg <= acc_add;
                end
            end
            ST_SQRT:
            begin
                if (sq_ge)
                begin
                    sq_x_reg   <= sq_x_reg - sq_sum;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
                cnt_reg    <= cnt_reg + CW'(1);
            end
            ST_NRM_SET:
            begin
                dv_rem_reg <= 32'(nrm_num[DVW-1:QW]);
                dv_num_reg <= nrm_num[QW-1:0];
                dv_div_reg <= sq_res_reg[31:0];
                dv_neg_reg <= cur[VEC_W-1];
                bas_reg    <= 1'b0;
                cnt_reg    <= '0;
            end
            ST_BAS_SET:
            begin
                dv_rem_reg <= 32'(bas_num[DVW-1:QW]);
                dv_num_reg <= bas_num[QW-1:0];
                dv_div_reg <= 32'(d_val);
                dv_neg_reg <= prod_reg[PW-1];
                bas_reg    <= 1'b1;
                cnt_reg    <= '0;
            end
            ST_DIV:
            begin
                dv_rem_reg <= dv_ge ? 32'(dv_t - {1'b0, dv_div_reg}) : dv_t[31:0];
                dv_num_reg <= dv_num_reg << 1;
                dv_q_reg   <= q_fin;
                cnt_reg    <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(QW - 1))
                begin
                    if (!bas_reg)
                    begin
                        nrm_reg[pass_reg][idx_reg[1:0]] <=
                            dv_neg_reg ? -$signed(q_clamp) : $signed(q_clamp);
                    end
                    else
                    begin
                        bq_reg[idx_reg[1:0]] <= dv_neg_reg ? -$signed(q_fin) : $signed(q_fin);
                    end
                    if (idx_reg == 3'd2)
                    begin
                        idx_reg <= '0;
                        acc_reg <= '0;
                        if (!bas_reg && kind_reg == KIND_BUILD_NT)
                            pass_reg <= 1'b1;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 3'd1;
                    end
                end
            end
            ST_CRS_ACC:
            begin
                if (idx_reg[0])
                begin
                    crs_reg[idx_reg[2:1]] <= FW'(rnd_frac(acc_sub));
                    acc_reg <= '0;
                end
                else
                begin
                    acc_reg <= acc_add;
                end
                idx_reg <= idx_reg + 3'd1;
            end
            ST_XF_ACC:
            begin
                if (jdx_reg == 2'd2)
                begin
                    // round, then saturate to the Q3.12 range
                    if (xf_rnd > SAT_HI)
                    begin
                        res_reg[idx_reg[1:0]] <= VEC_W'(SAT_HI);
                        sat_reg <= 1'b1;
                    end
                    else if (xf_rnd < SAT_LO)
                    begin
                        res_reg[idx_reg[1:0]] <= VEC_W'(SAT_LO);
                        sat_reg <= 1'b1;
                    end
                    else
                    begin
                        res_reg[idx_reg[1:0]] <= xf_rnd[VEC_W-1:0];
                    end
                    acc_reg <= '0;
                    jdx_reg <= '0;
                    idx_reg <= idx_reg + 3'd1;
                end
                else
                begin
                    acc_reg <= acc_add;
                    jdx_reg <= jdx_reg + 2'd1;
                end
            end
            ST_COMMIT:
            begin
                for (int i = 0; i < 3; i++)
                    res_reg[i] <= to_q12(nrm_reg[0][i]);
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg.out_x  <= res_reg[0];
            out_reg.out_y  <= res_reg[1];
            out_reg.out_z  <= res_reg[2];
            out_reg.status <= zero_reg ? STAT_ZERO : (sat_reg ? STAT_SAT : STAT_OK);
        end
    end

endmodule
